[design/tds_pkg.sv]
// Package for the timer divider search block.
// Holds field widths, the sequencer state type and the result item type.
// No dependencies.
package tds_pkg;

    localparam int unsigned CLK_W    = 32;
    localparam int unsigned RATE_W   = 32;
    localparam int unsigned SHIFT_W  = 3;
    localparam int unsigned PS_W     = 16;
    localparam int unsigned RELOAD_W = 16;

    // result tdata: divider_shift, prescale, reload, zero padded to bytes
    localparam int unsigned RES_BITS = SHIFT_W + PS_W + RELOAD_W;
    localparam int unsigned M_DATA_W = ((RES_BITS + 7) / 8) * 8;
    localparam int unsigned S_DATA_W = ((RATE_W + 7) / 8) * 8;

    localparam logic [CLK_W-1:0] CLK_RESET = 32'd8000000;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    typedef struct packed {
        logic [RELOAD_W-1:0] reload;
        logic [PS_W-1:0]     prescale;
        logic [SHIFT_W-1:0]  divider_shift;
    } result_t;

endpackage

[design/timer_divider_search_top.sv]
// Timer divider search: top level with candidate sequencer and serial divider.
// Depends on tds_pkg.
//
// Each request (tick rate in Hz) is searched over prescale 0..PRESCALE_STEPS-1
// (outer) and divider shift 0..DIVIDER_STEPS-1 (inner). One candidate is
// examined per cycle: the divisor is kept as a running value (add the rate for
// the next prescale, shift left for the next divider step) and a range compare
// against the system clock tells whether the reload fits. Only the first fitting
// candidate goes through the shift-subtract divider, and the finished result
// waits in ST_RESULT while the previous result item sits stalled in the output
// register. The block takes one item at a time (s_tready is low from
// acceptance until the result is loaded into the output register).
module timer_divider_search_top #(
    parameter int unsigned PRESCALE_STEPS = 65536,
    parameter int unsigned DIVIDER_STEPS  = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration: system_clock_hz
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tds_pkg::CLK_W-1:0]     cfg_data,
    // tdata: [31:0] tick_rate_hz
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tds_pkg::S_DATA_W-1:0]  s_tdata,
    // tdata: [2:0] divider_shift, [18:3] prescale, [34:19] reload, [39:35] zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tds_pkg::M_DATA_W-1:0]  m_tdata,
    // tuser: [0] found
    output logic                          m_tuser
);
    import tds_pkg::*;

    localparam logic [PS_W-1:0]    PS_LAST = PS_W'(PRESCALE_STEPS - 1);
    localparam logic [SHIFT_W-1:0] SH_LAST = SHIFT_W'(DIVIDER_STEPS - 1);
    localparam logic [3:0]         DIV_LAST = 4'(RELOAD_W - 1);

    state_t               state_reg, state_next;
    logic [CLK_W-1:0]     clk_hz_reg, clk_hz_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [CLK_W-1:0]     base_reg, base_next;   // (ps+1)*rate mod 2^32
    logic [CLK_W-1:0]     div_reg, div_next;     // base << sh mod 2^32
    logic [PS_W-1:0]      ps_reg, ps_next;
    logic [SHIFT_W-1:0]   sh_reg, sh_next;
    logic                 hit_reg, hit_next;
    logic [CLK_W-1:0]     rem_reg, rem_next;
    logic [RELOAD_W-1:0]  dvd_reg, dvd_next;
    logic [RELOAD_W-1:0]  quo_reg, quo_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg, m_found_next;
    result_t              m_res_reg, m_res_next;

    logic                 fits;
    logic [CLK_W:0]       trial;
    logic [CLK_W:0]       trial_diff;
    logic [CLK_W-1:0]     base_inc;
    logic                 out_free;

    // quotient in [2, 65535] <=> clk >= 2*div and clk < div*2^16
    assign fits = (div_reg != '0)
               && ({1'b0, clk_hz_reg} >= {div_reg, 1'b0})
               && ({{RELOAD_W{1'b0}}, clk_hz_reg} < {div_reg, {RELOAD_W{1'b0}}});

    assign trial      = {rem_reg, dvd_reg[RELOAD_W-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign base_inc   = base_reg + rate_reg;
    assign out_free   = !m_valid_reg || m_tready;

    always_comb begin
        state_next   = state_reg;
        clk_hz_next  = clk_hz_reg;
        rate_next    = rate_reg;
        base_next    = base_reg;
        div_next     = div_reg;
        ps_next      = ps_reg;
        sh_next      = sh_reg;
        hit_next     = hit_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_found_next = m_found_reg;
        m_res_next   = m_res_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (cfg_valid) begin
            clk_hz_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    rate_next  = s_tdata[RATE_W-1:0];
                    base_next  = s_tdata[RATE_W-1:0];
                    div_next   = s_tdata[RATE_W-1:0];
                    ps_next    = '0;
                    sh_next    = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (fits) begin
                    // quotient < 2^16, so the upper half alone is below div
                    rem_next   = {{(CLK_W-RELOAD_W){1'b0}}, clk_hz_reg[CLK_W-1:RELOAD_W]};
                    dvd_next   = clk_hz_reg[RELOAD_W-1:0];
                    quo_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end else if (sh_reg != SH_LAST) begin
                    div_next = {div_reg[CLK_W-2:0], 1'b0};
                    sh_next  = sh_reg + 1'b1;
                end else if (ps_reg != PS_LAST) begin
                    base_next = base_inc;
                    div_next  = base_inc;
                    sh_next   = '0;
                    ps_next   = ps_reg + 1'b1;
                end else begin
                    hit_next   = 1'b0;
                    state_next = ST_RESULT;
                end
            end
            ST_DIVIDE: begin
                if (!trial_diff[CLK_W]) begin
                    rem_next = trial_diff[CLK_W-1:0];
                    quo_next = {quo_reg[RELOAD_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[CLK_W-1:0];
                    quo_next = {quo_reg[RELOAD_W-2:0], 1'b0};
                end
                dvd_next = {dvd_reg[RELOAD_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    hit_next   = 1'b1;
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = hit_reg;
                    if (hit_reg) begin
                        m_res_next.divider_shift = sh_reg;
                        m_res_next.prescale      = ps_reg;
                        m_res_next.reload        = quo_reg - 1'b1;
                    end else begin
                        m_res_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            clk_hz_reg  <= CLK_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clk_hz_reg  <= clk_hz_next;
            m_valid_reg <= m_valid_next;
        end
        rate_reg    <= rate_next;
        base_reg    <= base_next;
        div_reg     <= div_next;
        ps_reg      <= ps_next;
        sh_reg      <= sh_next;
        hit_reg     <= hit_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        m_found_reg <= m_found_next;
        m_res_reg   <= m_res_next;
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = m_found_reg;
    assign m_tdata   = {{(M_DATA_W-RES_BITS){1'b0}}, m_res_reg};

endmodule

[design/tds_checker.sv]
// Port-level checks for timer_divider_search_top, attached by bind.
// Depends on tds_pkg.
module tds_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tds_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tuser
);
    import tds_pkg::*;

    // held result item must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while search in progress");

    // a failed search reports all-zero fields
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("failed search with nonzero fields");

    // a found reload lies strictly between 0 and 65535
    a_reload_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            m_tdata[RES_BITS-1:SHIFT_W+PS_W] != '0 &&
            m_tdata[RES_BITS-1:SHIFT_W+PS_W] != '1)
        else $error("found reload out of range");

endmodule

bind timer_divider_search_top tds_checker u_tds_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
